/* hdl/jtrc_pkg.sv */
// Package for the joint torque residual conditioner.
// Holds shared types, sizes and codes; no dependencies.
`timescale 1ns / 1ps
package jtrc_pkg;

  localparam int JOINTS  = 8;
  localparam int JIDX_W  = (JOINTS > 1) ? $clog2(JOINTS) : 1;

  localparam int TRQ_W   = 24;
  localparam int SPD_W   = 18;
  localparam int BIAS_W  = 36;
  localparam int SMTH_W  = 40;
  localparam int PROD_W  = 58;
  localparam int DEN_W   = 33;
  localparam int DIV_STEPS = PROD_W / 2;
  localparam int DCNT_W  = $clog2(DIV_STEPS);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIGN_NEG   = 3'd0,
    REG_DEADBAND   = 3'd1,
    REG_GATE_LOW   = 3'd2,
    REG_GATE_HIGH  = 3'd3,
    REG_FILT_GAIN  = 3'd4,
    REG_STARTUP    = 3'd5,
    REG_TARE       = 3'd6
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_ERR, ST_MUL1, ST_FILT, ST_DBND,
    ST_GATE, ST_DIVLD, ST_DIV, ST_DIVFIN, ST_FIN
  } jtrc_state_e;

  typedef enum logic [1:0] {
    PH_ZERO, PH_DIVIDE, PH_RUN
  } phase_e;

  typedef enum logic [1:0] {
    GT_PASS, GT_ZERO, GT_SCALE
  } gate_e;

  typedef struct packed {
    logic load_in;
    logic prep;
    logic err;
    logic mul1;
    logic filt;
    logic dbnd;
    logic gate;
    logic div_load;
    logic div_step;
    logic div_fin;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    phase_e phase_new;
    gate_e  gate;
    logic   div_last;
    logic   out_free;
  } status_t;

endpackage

/* hdl/joint_torque_residual_conditioner.sv */
// Top level of the joint torque residual conditioner.
// Depends on jtrc_pkg, jtrc_ctrl and jtrc_dp.
//
//  port group   dir  content
//  s_axis_*     in   joint sample word: tdata, tuser = link_alive, tlast = tick_end
//  m_axis_*     out  result word: tdata
//  cfg_*        in   register write: cfg_we_i, cfg_index_i, cfg_data_i
//
// One word at a time: startup and tare words go from the prep step straight to the final
// step; a run word steps through error, multiply, filter, deadband and gate; a tare divide
// word and a run word whose gate scales also pass through the shared radix-4 divider.
// Reset clears the counters, bias and filter state at once; no clearing pass.
// A finished word waits in the output register while the next word is taken;
// a stalled output holds the block only at its final step.
`timescale 1ns / 1ps
module joint_torque_residual_conditioner (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // joint_index[2:0], model_torque[26:3], sensed_torque[50:27],
  // joint_speed[68:51], zero fill [71:69]
  input  logic [71:0] s_axis_tdata,
  // link_alive[0]
  input  logic        s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // joint_out[2:0], torque_estimate[26:3], torque_untreated[50:27], zero fill [55:51]
  output logic [55:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [22:0] cfg_data_i
);
  import jtrc_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic [2:0]               out_joint;
  logic signed [TRQ_W-1:0]  out_est, out_raw;

  // sequencer: one word in flight, steps the datapath
  jtrc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // unpack the sample word straight into the datapath
  jtrc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .joint_i     (s_axis_tdata[2:0]),
    .model_i     (s_axis_tdata[26:3]),
    .sensed_i    (s_axis_tdata[50:27]),
    .speed_i     (s_axis_tdata[68:51]),
    .alive_i     (s_axis_tuser),
    .tend_i      (s_axis_tlast),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_joint_o (out_joint),
    .out_est_o   (out_est),
    .out_raw_o   (out_raw)
  );

  // pack the result word, zero fill to whole bytes
  assign m_axis_tdata = {5'b0, out_raw, out_est, out_joint};

endmodule

/* hdl/jtrc_ctrl.sv */
// Sequencer for the joint torque residual conditioner.
// Depends on jtrc_pkg; drives command strobes into jtrc_dp.
`timescale 1ns / 1ps
module jtrc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  jtrc_pkg::status_t status_i,
  output jtrc_pkg::cmd_t    cmd_o
);
  import jtrc_pkg::*;

  jtrc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        case (status_i.phase_new)
          PH_DIVIDE: state_d = ST_DIVLD;
          PH_RUN:    state_d = ST_ERR;
          default:   state_d = ST_FIN;
        endcase
      end
      ST_ERR: begin
        cmd_o.err = 1'b1;
        state_d   = ST_MUL1;
      end
      ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = ST_FILT;
      end
      ST_FILT: begin
        cmd_o.filt = 1'b1;
        state_d    = ST_DBND;
      end
      ST_DBND: begin
        cmd_o.dbnd = 1'b1;
        state_d    = ST_GATE;
      end
      ST_GATE: begin
        cmd_o.gate = 1'b1;
        state_d    = (status_i.gate == GT_SCALE) ? ST_DIVLD : ST_FIN;
      end
      ST_DIVLD: begin
        cmd_o.div_load = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = ST_DIVFIN;
      end
      ST_DIVFIN: begin
        cmd_o.div_fin = 1'b1;
        state_d       = ST_FIN;
      end
      ST_FIN: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  a_div_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |=> (state_q == ST_DIV || state_q == ST_DIVFIN))
    else $error("divider left early");

endmodule

/* hdl/jtrc_dp.sv */
// Datapath: config registers, tick counters, per-joint bias and filter state,
// multiplier and shared radix-4 divider. Depends on jtrc_pkg.
`timescale 1ns / 1ps
module jtrc_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [jtrc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [jtrc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [2:0]                        joint_i,
  input  logic signed [jtrc_pkg::TRQ_W-1:0] model_i,
  input  logic signed [jtrc_pkg::TRQ_W-1:0] sensed_i,
  input  logic signed [jtrc_pkg::SPD_W-1:0] speed_i,
  input  logic                              alive_i,
  input  logic                              tend_i,
  input  jtrc_pkg::cmd_t                    cmd_i,
  output jtrc_pkg::status_t                 status_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [2:0]                        out_joint_o,
  output logic signed [jtrc_pkg::TRQ_W-1:0] out_est_o,
  output logic signed [jtrc_pkg::TRQ_W-1:0] out_raw_o
);
  import jtrc_pkg::*;

  localparam logic signed [58:0] T_MAX = 59'sd8388607;
  localparam logic signed [58:0] T_MIN = -59'sd8388608;

  function automatic logic signed [TRQ_W-1:0] sat24(input logic signed [58:0] v);
    logic signed [TRQ_W-1:0] r;
    if (v > T_MAX) r = T_MAX[TRQ_W-1:0];
    else if (v < T_MIN) r = T_MIN[TRQ_W-1:0];
    else r = v[TRQ_W-1:0];
    return r;
  endfunction

  // Round to nearest (ties away from zero) after dropping 16 fraction bits.
  function automatic logic signed [42:0] rnd16(input logic signed [PROD_W-1:0] v);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] sum;
    logic signed [42:0] q;
    mag = v[PROD_W-1] ? (~v + 1'b1) : v;
    sum = mag + PROD_W'(32768);
    q   = {1'b0, sum[PROD_W-1:16]};
    return v[PROD_W-1] ? -q : q;
  endfunction

  // configuration
  logic                 sign_q;
  logic [22:0]          db_q;
  logic [16:0]          glo_q, ghi_q;
  logic [15:0]          gain_q, start_q;
  logic [11:0]          tare_q;

  // tick counters and per-joint state
  logic [15:0]          start_cnt_q;
  logic [11:0]          tare_cnt_q;
  logic                 tare_done_q;
  logic signed [BIAS_W-1:0] bias_q   [JOINTS];
  logic signed [SMTH_W-1:0] smooth_q [JOINTS];

  // item registers
  logic [2:0]           joint_q;
  logic signed [TRQ_W-1:0] model_q, sensed_q, r_q, e_q, est_q;
  logic signed [SPD_W-1:0] speed_q;
  logic                 alive_q, tend_q;
  phase_e               phase_q;
  logic signed [40:0]   diff_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [SMTH_W-1:0] s_q, d_q;

  // divider
  logic [PROD_W-1:0]    num_q;
  logic [DEN_W-1:0]     den_q, rem_q;
  logic                 neg_q;
  logic [DCNT_W-1:0]    dcnt_q;

  // output word
  logic                 out_valid_q;
  logic [2:0]           out_joint_q;
  logic signed [TRQ_W-1:0] out_est_q, out_raw_q;

  logic [JIDX_W-1:0]    jidx;
  logic                 jvalid;
  logic signed [24:0]   rsum;
  logic signed [TRQ_W-1:0] r_now;
  phase_e               phase_new;
  logic signed [BIAS_W-1:0] bias_rd;
  logic signed [SMTH_W-1:0] smooth_rd;
  logic signed [36:0]   e_wide;
  logic signed [TRQ_W-1:0] e_now;
  logic signed [42:0]   filt_step, s_wide;
  logic [SMTH_W-1:0]    s_mag;
  logic [SMTH_W-1:0]    thr;
  logic [SMTH_W-1:0]    d_mag;
  logic [SPD_W-1:0]     qd;
  gate_e                gate_cls;
  logic [16:0]          gap;
  logic [DEN_W-1:0]     den_gate;
  logic [PROD_W-1:0]    prod_mag;
  logic [BIAS_W-1:0]    bias_mag;
  logic [DEN_W:0]       rem_a, rem_b;
  logic [DEN_W-1:0]     rem_a1, rem_b1;
  logic                 qa, qb;
  logic signed [58:0]   quo_s;

  assign jidx      = JIDX_W'(joint_q);
  assign jvalid    = int'(joint_q) < JOINTS;
  assign bias_rd   = bias_q[jidx];
  assign smooth_rd = smooth_q[jidx];

  assign rsum  = sign_q ? (25'(model_q) + 25'(sensed_q)) : (25'(model_q) - 25'(sensed_q));
  assign r_now = sat24(59'(rsum));

  always_comb begin
    if (start_cnt_q < start_q) phase_new = PH_ZERO;
    else if (!tare_done_q) begin
      if (tare_cnt_q < tare_q || !jvalid || tare_cnt_q == '0) phase_new = PH_ZERO;
      else phase_new = PH_DIVIDE;
    end else if (jvalid) phase_new = PH_RUN;
    else phase_new = PH_ZERO;
  end

  assign e_wide = 37'(r_q) - 37'(bias_rd);
  assign e_now  = sat24(59'(e_wide));

  assign filt_step = rnd16(prod_q);
  assign s_wide    = 43'(smooth_rd) + filt_step;

  assign s_mag = s_q[SMTH_W-1] ? (~s_q + 1'b1) : s_q;
  assign thr   = {1'b0, db_q, 16'b0};
  assign d_mag = s_mag - thr;

  assign qd = speed_q[SPD_W-1] ? (~speed_q + 1'b1) : speed_q;
  always_comb begin
    if (qd <= 18'(glo_q)) gate_cls = GT_PASS;
    else if (qd >= 18'(ghi_q) || ghi_q <= glo_q) gate_cls = GT_ZERO;
    else gate_cls = GT_SCALE;
  end
  assign gap      = ghi_q - qd[16:0];
  assign den_gate = {ghi_q - glo_q, 16'b0};

  assign prod_mag = prod_q[PROD_W-1] ? (~prod_q + 1'b1) : prod_q;
  assign bias_mag = bias_rd[BIAS_W-1] ? (~bias_rd + 1'b1) : bias_rd;

  // two restoring steps per cycle
  always_comb begin
    rem_a  = {rem_q, num_q[PROD_W-1]};
    qa     = rem_a >= {1'b0, den_q};
    rem_a1 = qa ? DEN_W'(rem_a - {1'b0, den_q}) : rem_a[DEN_W-1:0];
    rem_b  = {rem_a1, num_q[PROD_W-2]};
    qb     = rem_b >= {1'b0, den_q};
    rem_b1 = qb ? DEN_W'(rem_b - {1'b0, den_q}) : rem_b[DEN_W-1:0];
  end
  assign quo_s = neg_q ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sign_q      <= 1'b0;
      db_q        <= 23'd512;
      glo_q       <= 17'd205;
      ghi_q       <= 17'd1229;
      gain_q      <= 16'd5958;
      start_q     <= 16'd600;
      tare_q      <= 12'd100;
      start_cnt_q <= '0;
      tare_cnt_q  <= '0;
      tare_done_q <= 1'b0;
      for (int i = 0; i < JOINTS; i++) begin
        bias_q[i]   <= '0;
        smooth_q[i] <= '0;
      end
      out_valid_q <= 1'b0;
      phase_q     <= PH_ZERO;
      dcnt_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_SIGN_NEG:  sign_q  <= cfg_data_i[0];
          REG_DEADBAND:  db_q    <= cfg_data_i[22:0];
          REG_GATE_LOW:  glo_q   <= cfg_data_i[16:0];
          REG_GATE_HIGH: ghi_q   <= cfg_data_i[16:0];
          REG_FILT_GAIN: gain_q  <= cfg_data_i[15:0];
          REG_STARTUP:   start_q <= cfg_data_i[15:0];
          REG_TARE:      tare_q  <= cfg_data_i[11:0];
          default: ;
        endcase
      end
      if (cmd_i.prep) begin
        phase_q <= phase_new;
        if (start_cnt_q < start_q) begin
          if (tend_q) start_cnt_q <= start_cnt_q + 1'b1;
        end else if (!tare_done_q) begin
          if (tare_cnt_q < tare_q) begin
            if (jvalid) bias_q[jidx] <= bias_rd + BIAS_W'(r_now);
            if (tend_q) tare_cnt_q <= tare_cnt_q + 1'b1;
          end else begin
            if (jvalid && tare_cnt_q == '0) bias_q[jidx] <= '0;
            if (tend_q) tare_done_q <= 1'b1;
          end
        end
      end
      if (cmd_i.filt) smooth_q[jidx] <= s_wide[SMTH_W-1:0];
      if (cmd_i.div_load) dcnt_q <= '0;
      else if (cmd_i.div_step) dcnt_q <= dcnt_q + 1'b1;
      if (cmd_i.div_fin && phase_q == PH_DIVIDE) bias_q[jidx] <= quo_s[BIAS_W-1:0];
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      joint_q  <= joint_i;
      model_q  <= model_i;
      sensed_q <= sensed_i;
      speed_q  <= speed_i;
      alive_q  <= alive_i;
      tend_q   <= tend_i;
    end
    if (cmd_i.prep) r_q <= r_now;
    if (cmd_i.err) begin
      e_q    <= e_now;
      diff_q <= $signed({e_now, 16'b0}) - 41'(smooth_rd);
    end
    if (cmd_i.mul1) prod_q <= diff_q * $signed({1'b0, gain_q});
    if (cmd_i.filt) s_q <= s_wide[SMTH_W-1:0];
    if (cmd_i.dbnd) begin
      if (s_mag <= thr) d_q <= '0;
      else d_q <= s_q[SMTH_W-1] ? -$signed(d_mag) : $signed(d_mag);
    end
    if (cmd_i.gate) begin
      case (gate_cls)
        GT_PASS:  est_q <= sat24(59'(rnd16(PROD_W'(d_q))));
        GT_SCALE: prod_q <= d_q * $signed({1'b0, gap});
        default:  est_q <= '0;
      endcase
    end
    if (cmd_i.div_load) begin
      rem_q <= '0;
      if (phase_q == PH_DIVIDE) begin
        den_q <= DEN_W'(tare_cnt_q);
        num_q <= PROD_W'(bias_mag) + PROD_W'(tare_cnt_q[11:1]);
        neg_q <= bias_rd[BIAS_W-1];
      end else begin
        den_q <= den_gate;
        num_q <= prod_mag + PROD_W'(den_gate[DEN_W-1:1]);
        neg_q <= prod_q[PROD_W-1];
      end
    end else if (cmd_i.div_step) begin
      rem_q <= rem_b1;
      num_q <= {num_q[PROD_W-3:0], qa, qb};
    end
    if (cmd_i.div_fin && phase_q != PH_DIVIDE) est_q <= sat24(quo_s);
    if (cmd_i.out_load) begin
      out_joint_q <= joint_q;
      out_est_q   <= (phase_q == PH_RUN && alive_q) ? est_q : '0;
      out_raw_q   <= (phase_q == PH_RUN) ? e_q : '0;
    end
  end

  assign status_o.phase_new = phase_new;
  assign status_o.gate      = gate_cls;
  assign status_o.div_last  = dcnt_q == DCNT_W'(DIV_STEPS - 1);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_joint_o = out_joint_q;
  assign out_est_o   = out_est_q;
  assign out_raw_o   = out_raw_q;

  a_tare_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(tare_done_q) |-> tare_done_q)
    else $error("tare flag cleared");

  a_tare_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tare_cnt_q != $past(tare_cnt_q)) |-> (tare_cnt_q == $past(tare_cnt_q) + 12'd1))
    else $error("tare counter jumped");

endmodule
